[rtl/core/udwd_pkg.sv]
// Shared types and constants for the ultrasonic distance and wall debounce block.
// Holds payload structs, configuration layout, register indexes and fixed-point constants.
// No dependencies.
package udwd_pkg;

    localparam int CAP_W       = 16;
    localparam int TIME_W      = 32;
    localparam int FRAC_W      = 8;
    localparam int DIST_W      = 16;
    localparam int CM_W        = 8;
    localparam int OFFSET_W    = 16;
    localparam int DEBOUNCE_W  = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Capture count is scaled by four to microseconds, then 58 us per centimetre.
    localparam int SCALE_SHIFT = 2;
    localparam int US_PER_CM   = 58;

    // Numerator of the divide and its reciprocal multiplier. The reciprocal is
    // rounded down, so the estimated quotient is exact or one too small.
    localparam int NUM_W       = CAP_W + SCALE_SHIFT + FRAC_W;
    localparam int RECIP_SHIFT = NUM_W + 6;
    localparam int RECIP_W     = RECIP_SHIFT - 5;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / US_PER_CM);
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUOT_W      = NUM_W - 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPTURE_OFFSET = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DISTANCE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DISTANCE   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WALL_DISTANCE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE       = 3'd4;

    // Configuration reset values.
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 16'd550;
    localparam logic [CM_W-1:0]       MAX_CM_RESET   = 8'd20;
    localparam logic [CM_W-1:0]       MIN_CM_RESET   = 8'd1;
    localparam logic [CM_W-1:0]       WALL_CM_RESET  = 8'd13;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd75;

    typedef struct packed {
        logic              new_capture;
        logic [CAP_W-1:0]  capture_count;
        logic [TIME_W-1:0] now_ms;
    } poll_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic              out_of_range;
        logic              wall_gone;
    } result_t;

    typedef struct packed {
        logic [OFFSET_W-1:0]   capture_offset;
        logic [CM_W-1:0]       max_distance_cm;
        logic [CM_W-1:0]       min_distance_cm;
        logic [CM_W-1:0]       wall_distance_cm;
        logic [DEBOUNCE_W-1:0] debounce_ms;
    } cfg_t;

    // A converted reading on its way to the tracking stage.
    typedef struct packed {
        logic              new_capture;
        logic              no_echo;
        logic [QUOT_W-1:0] dist_q8;
        logic [TIME_W-1:0] now_ms;
    } reading_t;

endpackage

[rtl/core/udwd_scale.sv]
// Capture-to-distance pipeline: input register, offset subtract, reciprocal multiply
// and quotient correction. Depends on udwd_pkg.
module udwd_scale
    import udwd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_stall,
    input  poll_t    in_data,
    output logic     rd_valid,
    input  logic     rd_take,
    output reading_t rd_data
);

    logic  s1_valid_reg, s1_valid_next;
    poll_t s1_data_reg;

    logic              s2_valid_reg, s2_valid_next;
    logic              s2_new_reg;
    logic              s2_no_echo_reg;
    logic [NUM_W-1:0]  s2_num_reg;
    logic [TIME_W-1:0] s2_now_reg;

    logic              s3_valid_reg, s3_valid_next;
    logic              s3_new_reg;
    logic              s3_no_echo_reg;
    logic [NUM_W-1:0]  s3_num_reg;
    logic [PROD_W-1:0] s3_prod_reg;
    logic [TIME_W-1:0] s3_now_reg;

    logic     s4_valid_reg, s4_valid_next;
    reading_t s4_data_reg;

    logic free1, free2, free3, free4;

    logic [CAP_W-1:0]  s1_diff;
    logic              s1_no_echo;
    logic [NUM_W-1:0]  s1_num;
    logic [QUOT_W-1:0] s3_quot;
    logic [NUM_W-1:0]  s3_rem;
    logic [QUOT_W-1:0] s3_dist;

    // Each stage can load when it is empty or its content moves on.
    assign free4 = !s4_valid_reg || rd_take;
    assign free3 = !s3_valid_reg || free4;
    assign free2 = !s2_valid_reg || free3;
    assign free1 = !s1_valid_reg || free2;
    assign in_stall = !free1;

    assign s1_valid_next = free1 ? in_valid     : s1_valid_reg;
    assign s2_valid_next = free2 ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = free3 ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next = free4 ? s3_valid_reg : s4_valid_reg;

    // A count at or below the offset has no usable echo.
    assign s1_no_echo = s1_data_reg.capture_count <= CAP_W'(cfg.capture_offset);
    assign s1_diff    = s1_data_reg.capture_count - CAP_W'(cfg.capture_offset);
    assign s1_num     = {s1_diff, {(SCALE_SHIFT + FRAC_W){1'b0}}};

    // The estimate is at most one short; one compare and increment fixes it.
    assign s3_quot = s3_prod_reg[RECIP_SHIFT +: QUOT_W];
    assign s3_rem  = s3_num_reg - NUM_W'(s3_quot) * NUM_W'(US_PER_CM);
    assign s3_dist = (s3_rem >= NUM_W'(US_PER_CM)) ? s3_quot + QUOT_W'(1) : s3_quot;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (free1 && in_valid) begin
            s1_data_reg <= in_data;
        end
        if (free2 && s1_valid_reg) begin
            s2_new_reg     <= s1_data_reg.new_capture;
            s2_no_echo_reg <= s1_no_echo;
            s2_num_reg     <= s1_num;
            s2_now_reg     <= s1_data_reg.now_ms;
        end
        if (free3 && s2_valid_reg) begin
            s3_new_reg     <= s2_new_reg;
            s3_no_echo_reg <= s2_no_echo_reg;
            s3_num_reg     <= s2_num_reg;
            s3_prod_reg    <= PROD_W'(s2_num_reg) * PROD_W'(RECIP);
            s3_now_reg     <= s2_now_reg;
        end
        if (free4 && s3_valid_reg) begin
            s4_data_reg.new_capture <= s3_new_reg;
            s4_data_reg.no_echo     <= s3_no_echo_reg;
            s4_data_reg.dist_q8     <= s3_dist;
            s4_data_reg.now_ms      <= s3_now_reg;
        end
    end

    assign rd_valid = s4_valid_reg;
    assign rd_data  = s4_data_reg;

endmodule

[rtl/core/udwd_track.sv]
// Range limiting, held distance and wall debounce state, plus the result register.
// Depends on udwd_pkg.
module udwd_track
    import udwd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     rd_valid,
    output logic     rd_take,
    input  reading_t rd_data,
    output logic     out_valid,
    input  logic     out_stall,
    output result_t  out_data
);

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;
    logic [DIST_W-1:0] held_reg, held_next;
    logic              range_reg, range_next;
    logic              gone_reg, gone_next;
    logic [TIME_W-1:0] poll_time_reg, poll_time_next;
    logic [TIME_W-1:0] steady_time_reg, steady_time_next;

    logic              accept;
    logic [DIST_W-1:0] max_q, min_q, wall_q, dist_sat;
    logic              ge_max, lt_min;
    logic [TIME_W-1:0] gap, since;
    logic              gap_big, since_big;

    assign rd_take = !out_valid_reg || !out_stall;
    assign accept  = rd_valid && rd_take;

    assign max_q  = DIST_W'({cfg.max_distance_cm, {FRAC_W{1'b0}}});
    assign min_q  = DIST_W'({cfg.min_distance_cm, {FRAC_W{1'b0}}});
    assign wall_q = DIST_W'({cfg.wall_distance_cm, {FRAC_W{1'b0}}});

    assign ge_max   = rd_data.no_echo || (rd_data.dist_q8 >= QUOT_W'(max_q));
    assign lt_min   = rd_data.dist_q8 < QUOT_W'(min_q);
    assign dist_sat = (|rd_data.dist_q8[QUOT_W-1:DIST_W]) ? {DIST_W{1'b1}}
                                                          : rd_data.dist_q8[DIST_W-1:0];

    // Both time differences are formed in parallel; when the gap restarts the
    // wait, the elapsed time since the restart is zero.
    assign gap       = rd_data.now_ms - poll_time_reg;
    assign since     = rd_data.now_ms - steady_time_reg;
    assign gap_big   = gap > TIME_W'(cfg.debounce_ms);
    assign since_big = since > TIME_W'(cfg.debounce_ms);

    always_comb begin
        held_next        = held_reg;
        range_next       = range_reg;
        gone_next        = gone_reg;
        poll_time_next   = poll_time_reg;
        steady_time_next = steady_time_reg;
        out_valid_next   = rd_take ? rd_valid : out_valid_reg;
        out_data_next    = out_data_reg;
        if (accept) begin
            poll_time_next = rd_data.now_ms;
            if (rd_data.new_capture) begin
                if (ge_max) begin
                    // The first reading beyond range keeps the previous distance.
                    if (range_reg) begin
                        held_next = max_q;
                    end
                    range_next = 1'b1;
                end
                else if (lt_min) begin
                    held_next  = min_q;
                    range_next = 1'b0;
                end
                else begin
                    held_next  = dist_sat;
                    range_next = 1'b0;
                end
            end
            if (held_next > wall_q) begin
                steady_time_next = gap_big ? rd_data.now_ms : steady_time_reg;
                gone_next        = gone_reg || (!gap_big && since_big);
            end
            else begin
                steady_time_next = rd_data.now_ms;
                gone_next        = 1'b0;
            end
            out_data_next.distance_q8  = held_next;
            out_data_next.out_of_range = range_next;
            out_data_next.wall_gone    = gone_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            held_reg        <= '0;
            range_reg       <= 1'b0;
            gone_reg        <= 1'b0;
            poll_time_reg   <= '0;
            steady_time_reg <= '0;
        end
        else begin
            out_valid_reg   <= out_valid_next;
            held_reg        <= held_next;
            range_reg       <= range_next;
            gone_reg        <= gone_next;
            poll_time_reg   <= poll_time_next;
            steady_time_reg <= steady_time_next;
        end
    end

    always_ff @(posedge clk) begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/ultrasonic_distance_wall_debounce_top.sv]
// An accepted input beat passes through the udwd_scale stages and then the result register in udwd_track.
// Throughput: one beat per cycle, including the state update, unless out_stall holds the pipeline.
// Each result register stage loads while the next one drains, so stalls do not cost bubbles.
// Reset (rst_n low, asynchronous) empties the pipeline, clears held distance, flags and
// time stamps, and loads the configuration registers with their default values.
// Depends on udwd_pkg, udwd_scale and udwd_track.
module ultrasonic_distance_wall_debounce_top
    import udwd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  poll_t                  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output result_t                out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // The configuration registers. A write beat is always taken; an index beyond
    // the register list is dropped. The user must write only while the block is idle, so
    // the pipeline never sees a change in the middle of an item; the block does not check.
    cfg_t cfg_reg, cfg_next;

    // The reading channel between the converter pipeline and the tracking stage.
    logic     rd_valid;
    logic     rd_take;
    reading_t rd_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_CAPTURE_OFFSET: cfg_next.capture_offset   = cfg_data[OFFSET_W-1:0];
                CFG_MAX_DISTANCE:   cfg_next.max_distance_cm  = cfg_data[CM_W-1:0];
                CFG_MIN_DISTANCE:   cfg_next.min_distance_cm  = cfg_data[CM_W-1:0];
                CFG_WALL_DISTANCE:  cfg_next.wall_distance_cm = cfg_data[CM_W-1:0];
                CFG_DEBOUNCE:       cfg_next.debounce_ms      = cfg_data[DEBOUNCE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.capture_offset   <= OFFSET_RESET;
            cfg_reg.max_distance_cm  <= MAX_CM_RESET;
            cfg_reg.min_distance_cm  <= MIN_CM_RESET;
            cfg_reg.wall_distance_cm <= WALL_CM_RESET;
            cfg_reg.debounce_ms      <= DEBOUNCE_RESET;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // Four stages turn a capture count into a distance in Q.8 centimetres:
    // input register, offset subtract, reciprocal multiply by 1/58, and a
    // one-step quotient correction. None of them depends on tracking state.
    udwd_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .rd_valid (rd_valid),
        .rd_take  (rd_take),
        .rd_data  (rd_data)
    );

    // The last stage applies the range limits, updates the held distance and the
    // debounce time stamps, and writes the result register in the same cycle,
    // so the next reading sees the updated state.
    udwd_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rd_valid  (rd_valid),
        .rd_take   (rd_take),
        .rd_data   (rd_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[rtl/core/udwd_checker.sv]
// Port-level checker for the ultrasonic distance block, with its bind to the top level.
// Depends on udwd_pkg and ultrasonic_distance_wall_debounce_top.
module udwd_checker
    import udwd_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input poll_t                  in_data,
    input logic                   out_valid,
    input logic                   out_stall,
    input result_t                out_data,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PIPE_DEPTH = 5;

    logic [2:0] count_reg, count_next;
    logic       in_beat, out_beat;

    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid && !out_stall;

    always_comb begin
        count_next = count_reg + 3'(in_beat) - 3'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            count_reg <= '0;
        end
        else begin
            count_reg <= count_next;
        end
    end

    // A stalled result beat stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed or vanished");

    // Items in flight never exceed the number of pipeline stages.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    // A result is only offered for an item that was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 3'd0)
        else $error("result offered with no item in flight");

    // An empty block always takes input.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 3'd0 |-> !in_stall)
        else $error("input stalled while the block is empty");

endmodule

bind ultrasonic_distance_wall_debounce_top udwd_checker u_checker (.*);
